[rtl/mma_pkg.sv]
`timescale 1ns / 1ps

package mma_pkg;

   localparam int unsigned CHAN_BITS = 6;

   typedef enum logic {
      ACTION_PUSH = 1'b0,
      ACTION_READ = 1'b1
   } action_type;

   typedef enum logic {
      STATE_CLEAR = 1'b0,
      STATE_RUN   = 1'b1
   } state_type;

   typedef struct packed {
      logic                 valid;
      logic [CHAN_BITS-1:0] channel;
   } tag_type;

endpackage

[rtl/multichannel_moving_average_core.sv]
`timescale 1ns / 1ps
// An accepted item passes three stages around the memories, three in the reciprocal-multiply
// divider and the output register before its result appears.
// Throughput: one item per cycle, set by the channel and sample memories'
// read-modify-write loop with forwarding; the whole pipeline stalls while the skid entry is full.
// Reset: synchronous; afterwards a clearing pass zeroes both memories, stepping through
// max(CHANNEL_COUNT, 2) * 2**clog2(WINDOW_DEPTH) sample addresses (1024 at defaults), req_tready low.

module multichannel_moving_average_core #(
   parameter int unsigned WINDOW_DEPTH  = 16,
   parameter int unsigned CHANNEL_COUNT = 64,
   parameter int unsigned SAMPLE_BITS   = 24
) (
   input  logic clock,
   input  logic reset,

   input  logic req_tvalid,
   output logic req_tready,
   // Fields from bit 0: channel, sample.
   input  logic [((mma_pkg::CHAN_BITS + SAMPLE_BITS + 7) / 8) * 8 - 1:0] req_tdata,
   // Fields from bit 0: action.
   input  logic req_tuser,

   output logic rsp_tvalid,
   input  logic rsp_tready,
   // Fields from bit 0: channel_out, average.
   output logic [((mma_pkg::CHAN_BITS + SAMPLE_BITS + 7) / 8) * 8 - 1:0] rsp_tdata
);

   localparam int unsigned CHAN_BITS        = mma_pkg::CHAN_BITS;
   localparam int unsigned DATA_BITS        = ((CHAN_BITS + SAMPLE_BITS + 7) / 8) * 8;
   localparam int unsigned PTR_BITS         = $clog2(WINDOW_DEPTH);
   localparam int unsigned SUM_BITS         = SAMPLE_BITS + PTR_BITS;
   localparam int unsigned CH_SLOTS         = (CHANNEL_COUNT > 1) ? CHANNEL_COUNT : 2;
   localparam int unsigned CH_ADDR_BITS     = $clog2(CH_SLOTS);
   localparam int unsigned CH_WIDE_BITS     =
      (CH_ADDR_BITS > CHAN_BITS) ? CH_ADDR_BITS : CHAN_BITS;
   localparam int unsigned CH_WORD_BITS     = PTR_BITS + SUM_BITS;
   localparam int unsigned SAMPLE_DEPTH     = CH_SLOTS << PTR_BITS;
   localparam int unsigned SAMPLE_ADDR_BITS = CH_ADDR_BITS + PTR_BITS;
   localparam logic [SAMPLE_ADDR_BITS-1:0] CLEAR_LAST = SAMPLE_ADDR_BITS'(SAMPLE_DEPTH - 1);
   localparam logic [PTR_BITS:0] PTR_LAST = (PTR_BITS + 1)'(WINDOW_DEPTH - 1);

   // Clearing pass.
   mma_pkg::state_type            state_ff;
   mma_pkg::state_type            state_in;
   logic [SAMPLE_ADDR_BITS-1:0]   clear_addr_ff;
   logic [SAMPLE_ADDR_BITS-1:0]   clear_addr_in;
   logic                          clearing;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= mma_pkg::STATE_CLEAR;
         clear_addr_ff <= '0;
      end else begin
         state_ff      <= state_in;
         clear_addr_ff <= clear_addr_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      clear_addr_in = clear_addr_ff;
      clearing      = 1'b0;
      unique case (state_ff)
         mma_pkg::STATE_CLEAR: begin
            clearing      = 1'b1;
            clear_addr_in = clear_addr_ff + 1'b1;
            if (clear_addr_ff == CLEAR_LAST) begin
               state_in = mma_pkg::STATE_RUN;
            end
         end
         mma_pkg::STATE_RUN: begin
            clearing = 1'b0;
         end
      endcase
   end

   // Handshake and item decode.
   logic skid_valid_ff;
   logic advance;
   logic accept;

   assign advance    = ~skid_valid_ff;
   assign req_tready = (state_ff == mma_pkg::STATE_RUN) && advance;
   assign accept     = req_tvalid && req_tready;

   logic [CHAN_BITS-1:0]          req_channel;
   logic signed [SAMPLE_BITS-1:0] req_sample;
   logic [CH_WIDE_BITS-1:0]       req_chan_wide;
   logic [CH_ADDR_BITS-1:0]       req_addr;
   logic                          req_ok;
   logic                          req_push;

   assign req_channel   = req_tdata[CHAN_BITS-1:0];
   assign req_sample    = req_tdata[CHAN_BITS+SAMPLE_BITS-1:CHAN_BITS];
   assign req_chan_wide = CH_WIDE_BITS'(req_channel);
   assign req_addr      = req_chan_wide[CH_ADDR_BITS-1:0];
   assign req_ok        = ((CH_WIDE_BITS + 1)'(req_channel) <
                           (CH_WIDE_BITS + 1)'(CHANNEL_COUNT));
   assign req_push      = (req_tuser == mma_pkg::ACTION_PUSH);

   // Pipeline registers.
   logic                          s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;
   logic                          s1_ok_ff, s2_ok_ff, s3_ok_ff, s4_ok_ff;
   logic                          s1_push_ff, s2_push_ff;
   logic [CHAN_BITS-1:0]          s1_chan_ff, s2_chan_ff, s3_chan_ff;
   logic [CH_ADDR_BITS-1:0]       s1_addr_ff, s2_addr_ff, s3_addr_ff, s4_addr_ff;
   logic signed [SAMPLE_BITS-1:0] s1_sample_ff, s2_sample_ff;
   logic [PTR_BITS-1:0]           s2_ptr_ff, s3_ptr_ff;
   logic signed [SUM_BITS-1:0]    s2_sum_ff, s3_sum_ff, s4_sum_ff;

   // Memories.
   logic                          ch_wen;
   logic [CH_ADDR_BITS-1:0]       ch_waddr;
   logic [CH_WORD_BITS-1:0]       ch_wdata;
   logic [CH_WORD_BITS-1:0]       ch_rdata;
   logic                          smp_wen;
   logic [SAMPLE_ADDR_BITS-1:0]   smp_waddr;
   logic [SAMPLE_ADDR_BITS-1:0]   smp_raddr;
   logic [SAMPLE_BITS-1:0]        smp_wdata;
   logic [SAMPLE_BITS-1:0]        smp_rdata;

   // Stage 1: pointer with forwarding, sample memory access.
   logic [PTR_BITS-1:0]           ram_ptr;
   logic signed [SUM_BITS-1:0]    ram_sum;
   logic [PTR_BITS-1:0]           ptr_cur;
   logic [PTR_BITS-1:0]           ptr_next;

   assign ram_ptr = ch_rdata[CH_WORD_BITS-1:SUM_BITS];
   assign ram_sum = ch_rdata[SUM_BITS-1:0];

   always_comb begin
      priority if (s2_valid_ff && s2_ok_ff && (s2_addr_ff == s1_addr_ff)) begin
         ptr_cur = s2_ptr_ff;
      end else if (s3_valid_ff && s3_ok_ff && (s3_addr_ff == s1_addr_ff)) begin
         ptr_cur = s3_ptr_ff;
      end else begin
         ptr_cur = ram_ptr;
      end
      if (!s1_push_ff) begin
         ptr_next = ptr_cur;
      end else if ((PTR_BITS + 1)'(ptr_cur) == PTR_LAST) begin
         ptr_next = '0;
      end else begin
         ptr_next = ptr_cur + 1'b1;
      end
   end

   // Stage 2: running sum with forwarding.
   logic signed [SAMPLE_BITS-1:0] old_sample;
   logic signed [SUM_BITS-1:0]    sum_cur;
   logic signed [SUM_BITS-1:0]    new_sum;
   logic signed [SUM_BITS-1:0]    result_sum;

   assign old_sample = smp_rdata;

   always_comb begin
      priority if (s3_valid_ff && s3_ok_ff && (s3_addr_ff == s2_addr_ff)) begin
         sum_cur = s3_sum_ff;
      end else if (s4_valid_ff && s4_ok_ff && (s4_addr_ff == s2_addr_ff)) begin
         sum_cur = s4_sum_ff;
      end else begin
         sum_cur = s2_sum_ff;
      end
      if (s2_push_ff) begin
         new_sum = sum_cur - SUM_BITS'(old_sample) + SUM_BITS'(s2_sample_ff);
      end else begin
         new_sum = sum_cur;
      end
      result_sum = s2_ok_ff ? new_sum : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= accept;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_ok_ff     <= req_ok;
         s1_push_ff   <= req_push;
         s1_chan_ff   <= req_channel;
         s1_addr_ff   <= req_addr;
         s1_sample_ff <= req_sample;

         s2_ok_ff     <= s1_ok_ff;
         s2_push_ff   <= s1_push_ff;
         s2_chan_ff   <= s1_chan_ff;
         s2_addr_ff   <= s1_addr_ff;
         s2_sample_ff <= s1_sample_ff;
         s2_ptr_ff    <= ptr_next;
         s2_sum_ff    <= ram_sum;

         s3_ok_ff     <= s2_ok_ff;
         s3_chan_ff   <= s2_chan_ff;
         s3_addr_ff   <= s2_addr_ff;
         s3_ptr_ff    <= s2_ptr_ff;
         s3_sum_ff    <= result_sum;

         s4_ok_ff     <= s3_ok_ff;
         s4_addr_ff   <= s3_addr_ff;
         s4_sum_ff    <= s3_sum_ff;
      end
   end

   assign ch_wen   = clearing || (advance && s2_valid_ff && s2_ok_ff && s2_push_ff);
   assign ch_waddr = clearing ? clear_addr_ff[SAMPLE_ADDR_BITS-1:PTR_BITS] : s2_addr_ff;
   assign ch_wdata = clearing ? '0 : {s2_ptr_ff, new_sum};

   assign smp_raddr = {s1_addr_ff, ptr_cur};
   assign smp_wen   = clearing || (advance && s1_valid_ff && s1_ok_ff && s1_push_ff);
   assign smp_waddr = clearing ? clear_addr_ff : smp_raddr;
   assign smp_wdata = clearing ? '0 : s1_sample_ff;

   mma_ram #(
      .WIDTH (CH_WORD_BITS),
      .DEPTH (CH_SLOTS)
   ) u_channel_ram (
      .clock (clock),
      .wen   (ch_wen),
      .waddr (ch_waddr),
      .wdata (ch_wdata),
      .ren   (advance),
      .raddr (req_addr),
      .rdata (ch_rdata)
   );

   mma_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (SAMPLE_DEPTH)
   ) u_sample_ram (
      .clock (clock),
      .wen   (smp_wen),
      .waddr (smp_waddr),
      .wdata (smp_wdata),
      .ren   (advance),
      .raddr (smp_raddr),
      .rdata (smp_rdata)
   );

   // Division by the window depth.
   mma_pkg::tag_type              div_in_tag;
   mma_pkg::tag_type              div_out_tag;
   logic signed [SAMPLE_BITS-1:0] div_quotient;

   assign div_in_tag.valid   = s3_valid_ff;
   assign div_in_tag.channel = s3_chan_ff;

   mma_floor_div #(
      .WINDOW_DEPTH (WINDOW_DEPTH),
      .SAMPLE_BITS  (SAMPLE_BITS)
   ) u_floor_div (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .in_tag   (div_in_tag),
      .dividend (s3_sum_ff),
      .out_tag  (div_out_tag),
      .quotient (div_quotient)
   );

   // Output register with a skid entry.
   logic                          pipe_valid;
   logic                          out_valid_ff, out_valid_in;
   logic [CHAN_BITS-1:0]          out_chan_ff, out_chan_in;
   logic [SAMPLE_BITS-1:0]        out_avg_ff, out_avg_in;
   logic                          skid_valid_in;
   logic [CHAN_BITS-1:0]          skid_chan_ff, skid_chan_in;
   logic [SAMPLE_BITS-1:0]        skid_avg_ff, skid_avg_in;

   assign pipe_valid = div_out_tag.valid && advance;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_chan_in   = out_chan_ff;
      out_avg_in    = out_avg_ff;
      skid_valid_in = skid_valid_ff;
      skid_chan_in  = skid_chan_ff;
      skid_avg_in   = skid_avg_ff;
      if (rsp_tready || !out_valid_ff) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_chan_in   = skid_chan_ff;
            out_avg_in    = skid_avg_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = pipe_valid;
            out_chan_in  = div_out_tag.channel;
            out_avg_in   = div_quotient;
         end
      end else if (pipe_valid) begin
         skid_valid_in = 1'b1;
         skid_chan_in  = div_out_tag.channel;
         skid_avg_in   = div_quotient;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_chan_ff  <= out_chan_in;
      out_avg_ff   <= out_avg_in;
      skid_chan_ff <= skid_chan_in;
      skid_avg_ff  <= skid_avg_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = DATA_BITS'({out_avg_ff, out_chan_ff});

endmodule

[rtl/mma_ram.sv]
`timescale 1ns / 1ps

module mma_ram #(
   parameter int unsigned WIDTH = 24,
   parameter int unsigned DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wen,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     ren,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // A read and a write to the same address in one cycle return the old word.
   always_ff @(posedge clock) begin
      if (ren) begin
         rdata_ff <= mem[raddr];
      end
      if (wen) begin
         mem[waddr] <= wdata;
      end
   end

   assign rdata = rdata_ff;

endmodule

[rtl/mma_floor_div.sv]
`timescale 1ns / 1ps

module mma_floor_div #(
   parameter int unsigned WINDOW_DEPTH = 16,
   parameter int unsigned SAMPLE_BITS  = 24
) (
   input  logic                                                clock,
   input  logic                                                reset,
   input  logic                                                advance,
   input  mma_pkg::tag_type                                    in_tag,
   input  logic signed [SAMPLE_BITS+$clog2(WINDOW_DEPTH)-1:0] dividend,
   output mma_pkg::tag_type                                    out_tag,
   output logic signed [SAMPLE_BITS-1:0]                       quotient
);

   localparam int unsigned REM_BITS     = $clog2(WINDOW_DEPTH);
   localparam int unsigned SUM_BITS     = SAMPLE_BITS + REM_BITS;
   localparam int unsigned SHIFT        = SUM_BITS + REM_BITS;
   localparam int unsigned RECIP_BITS   = SUM_BITS + 1;
   localparam int unsigned LO_BITS      = SUM_BITS / 2;
   localparam int unsigned HI_BITS      = SUM_BITS - LO_BITS;
   localparam int unsigned LO_PROD_BITS = LO_BITS + RECIP_BITS;
   localparam int unsigned HI_PROD_BITS = HI_BITS + RECIP_BITS;
   localparam int unsigned PROD_BITS    = SUM_BITS + RECIP_BITS;
   localparam logic [SUM_BITS-1:0] OFFSET = SUM_BITS'(WINDOW_DEPTH) << (SAMPLE_BITS - 1);
   localparam logic [RECIP_BITS-1:0] RECIP =
      RECIP_BITS'(((64'd1 << SHIFT) + 64'(WINDOW_DEPTH) - 64'd1) / 64'(WINDOW_DEPTH));
   localparam logic [SAMPLE_BITS-1:0] SIGN_FLIP = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

   // The offset makes the dividend non-negative, so the rounded-up reciprocal
   // gives the exact floor; flipping the quotient's top bit removes the offset.
   logic [SUM_BITS-1:0]     biased_ff, biased_in;
   logic [LO_PROD_BITS-1:0] prod_lo_ff, prod_lo_in;
   logic [HI_PROD_BITS-1:0] prod_hi_ff, prod_hi_in;
   logic [PROD_BITS-1:0]    product;
   logic [SAMPLE_BITS-1:0]  quot_ff, quot_in;
   mma_pkg::tag_type        tag_a_ff, tag_b_ff, tag_c_ff;

   always_comb begin
      biased_in  = SUM_BITS'(dividend) + OFFSET;
      prod_lo_in = LO_PROD_BITS'(biased_ff[LO_BITS-1:0]) * LO_PROD_BITS'(RECIP);
      prod_hi_in = HI_PROD_BITS'(biased_ff[SUM_BITS-1:LO_BITS]) * HI_PROD_BITS'(RECIP);
      product    = (PROD_BITS'(prod_hi_ff) << LO_BITS) + PROD_BITS'(prod_lo_ff);
      quot_in    = product[SHIFT +: SAMPLE_BITS] ^ SIGN_FLIP;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_a_ff <= '0;
         tag_b_ff <= '0;
         tag_c_ff <= '0;
      end else if (advance) begin
         tag_a_ff <= in_tag;
         tag_b_ff <= tag_a_ff;
         tag_c_ff <= tag_b_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         biased_ff  <= biased_in;
         prod_lo_ff <= prod_lo_in;
         prod_hi_ff <= prod_hi_in;
         quot_ff    <= quot_in;
      end
   end

   assign out_tag  = tag_c_ff;
   assign quotient = quot_ff;

endmodule
